// ===== src/olte_pkg.sv =====
// Shared types and constants for the ordered list table engine.
// Holds operation and status codes and the fixed field widths.
// Depends on nothing.
package olte_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FoundW  = 4;
  localparam int unsigned CountW  = 5;

  // Request operations; codes 6 and 7 are no-ops
  typedef enum logic [KindW-1:0] {
    KIND_APPEND    = 3'd0,
    KIND_INSERT    = 3'd1,
    KIND_DELETE    = 3'd2,
    KIND_FIND      = 3'd3,
    KIND_OVERWRITE = 3'd4,
    KIND_CLEAR     = 3'd5
  } kind_e;

  // Response status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

endpackage

// ===== src/ordered_list_table_engine.sv =====
// Ordered list table engine: packed list of signed 32-bit entries in a local memory.
// Depends on olte_pkg for operation and status codes and field widths.
//
// The block holds up to CAPACITY signed 32-bit entries packed from index 0 and serves
// one transaction at a time: append, insert, delete, find, overwrite or clear, each
// giving one response with status, found index and the length afterwards. Entries sit
// in a memory with one write and one registered read port, and a small sequencer moves
// entries through that port one per cycle; that port sets the time taken. Append,
// overwrite, clear, no-op codes and every rejected request go straight to the
// response; insert walks from the tail down to the position, delete walks from just
// past the position up to the tail, and find walks from index 0 to the first match
// or the end of the list. A response that finds the output register still occupied
// waits for it. A new transaction is taken while the previous response still waits
// in the output register. Clear only resets the length; no memory sweep is needed.
module ordered_list_table_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [olte_pkg::KindW-1:0]         kind_i,
  input  logic [olte_pkg::PosW-1:0]          position_i,
  input  logic signed [olte_pkg::ValueW-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [olte_pkg::StatusW-1:0]       status_o,
  output logic [olte_pkg::FoundW-1:0]        found_index_o,
  output logic [olte_pkg::CountW-1:0]        count_after_o
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = (LW > olte_pkg::PosW) ? LW : olte_pkg::PosW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_FIND,
    S_RESP
  } state_e;

  state_e state_q;

  logic [LW-1:0]                 len_q;
  logic [LW-1:0]                 ptr_q;
  logic [LW-1:0]                 pos_q;
  logic [olte_pkg::ValueW-1:0]   val_q;
  logic                          pend_q;
  logic [AW-1:0]                 pend_addr_q;
  olte_pkg::status_e             res_status_q;
  logic [AW-1:0]                 res_found_q;

  logic                          out_valid_q;
  logic [olte_pkg::StatusW-1:0]  status_q;
  logic [olte_pkg::FoundW-1:0]   found_q;
  logic [olte_pkg::CountW-1:0]   count_q;

  // Element memory
  logic [olte_pkg::ValueW-1:0]   mem_q [CAPACITY];
  logic [olte_pkg::ValueW-1:0]   rd_data_q;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [olte_pkg::ValueW-1:0]   mem_wdata;
  logic [AW-1:0]                 mem_raddr;

  // Request decode and checks against the current length
  logic                          accept;
  logic                          full;
  logic                          pos_gt_len;
  logic                          pos_ge_len;
  logic [CW-1:0]                 pos_ext;
  logic [CW-1:0]                 len_ext;
  logic [LW-1:0]                 ptr_dec;
  logic                          ins_step;
  logic                          walk_step;
  logic                          hit;
  logic                          slot_free;
  olte_pkg::kind_e               kind;

  assign accept     = in_valid_i && in_ready_o;
  assign kind       = olte_pkg::kind_e'(kind_i);
  assign full       = (len_q >= LW'(CAPACITY));
  assign pos_ext    = CW'(position_i);
  assign len_ext    = CW'(len_q);
  assign pos_gt_len = (pos_ext > len_ext);
  assign pos_ge_len = (pos_ext >= len_ext);
  assign ptr_dec    = ptr_q - 1'b1;
  assign ins_step   = (ptr_q > pos_q);
  assign walk_step  = (ptr_q < len_q);
  assign hit        = pend_q && (rd_data_q == val_q);
  assign slot_free  = !out_valid_q || out_ready_i;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign count_after_o = count_q;

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr_q;
    mem_wdata = rd_data_q;
    mem_raddr = ptr_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept && kind == olte_pkg::KIND_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_waddr = len_q[AW-1:0];
          mem_wdata = value_i;
        end else if (accept && kind == olte_pkg::KIND_OVERWRITE && !pos_ge_len) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(position_i);
          mem_wdata = value_i;
        end
      end
      S_INS: begin
        mem_raddr = ptr_dec[AW-1:0];
        if (pend_q) begin
          mem_we = 1'b1;
        end else if (!ins_step) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AW-1:0];
          mem_wdata = val_q;
        end
      end
      S_DEL: begin
        mem_we = pend_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // Sequencer, length and registered response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= '0;
      ptr_q        <= '0;
      pos_q        <= '0;
      val_q        <= '0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      found_q      <= '0;
      count_q      <= '0;
      res_status_q <= olte_pkg::ST_OK;
      res_found_q  <= '0;
    end else begin
      // Response leaves unless a new one is loaded in the same cycle
      if (out_valid_q && out_ready_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          pend_q <= 1'b0;
          if (accept) begin
            pos_q       <= LW'(position_i);
            val_q       <= value_i;
            res_found_q <= '0;
            unique case (kind)
              olte_pkg::KIND_APPEND: begin
                state_q <= S_RESP;
                if (full) begin
                  res_status_q <= olte_pkg::ST_FULL;
                end else begin
                  res_status_q <= olte_pkg::ST_OK;
                  len_q        <= len_q + 1'b1;
                end
              end
              olte_pkg::KIND_INSERT: begin
                if (full) begin
                  res_status_q <= olte_pkg::ST_FULL;
                  state_q      <= S_RESP;
                end else if (pos_gt_len) begin
                  res_status_q <= olte_pkg::ST_BADPOS;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= olte_pkg::ST_OK;
                  ptr_q        <= len_q;
                  state_q      <= S_INS;
                end
              end
              olte_pkg::KIND_DELETE: begin
                if (len_q == '0) begin
                  res_status_q <= olte_pkg::ST_EMPTY;
                  state_q      <= S_RESP;
                end else if (pos_ge_len) begin
                  res_status_q <= olte_pkg::ST_BADPOS;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= olte_pkg::ST_OK;
                  ptr_q        <= LW'(position_i) + 1'b1;
                  state_q      <= S_DEL;
                end
              end
              olte_pkg::KIND_FIND: begin
                res_status_q <= olte_pkg::ST_OK;
                ptr_q        <= '0;
                state_q      <= S_FIND;
              end
              olte_pkg::KIND_OVERWRITE: begin
                res_status_q <= pos_ge_len ? olte_pkg::ST_BADPOS : olte_pkg::ST_OK;
                state_q      <= S_RESP;
              end
              olte_pkg::KIND_CLEAR: begin
                res_status_q <= olte_pkg::ST_OK;
                len_q        <= '0;
                state_q      <= S_RESP;
              end
              default: begin
                res_status_q <= olte_pkg::ST_OK;
                state_q      <= S_RESP;
              end
            endcase
          end
        end
        // Shift entries up from the tail, then drop the new value in
        S_INS: begin
          pend_q <= ins_step;
          if (ins_step) begin
            pend_addr_q <= ptr_q[AW-1:0];
            ptr_q       <= ptr_dec;
          end else if (!pend_q) begin
            len_q   <= len_q + 1'b1;
            state_q <= S_RESP;
          end
        end
        // Shift entries down towards the deleted slot
        S_DEL: begin
          pend_q <= walk_step;
          if (walk_step) begin
            pend_addr_q <= ptr_dec[AW-1:0];
            ptr_q       <= ptr_q + 1'b1;
          end else if (!pend_q) begin
            len_q   <= len_q - 1'b1;
            state_q <= S_RESP;
          end
        end
        // Linear scan; the compare comes in the cycle after the read, on the registered data
        S_FIND: begin
          pend_q <= !hit && walk_step;
          if (hit) begin
            res_found_q <= pend_addr_q;
            state_q     <= S_RESP;
          end else if (walk_step) begin
            pend_addr_q <= ptr_q[AW-1:0];
            ptr_q       <= ptr_q + 1'b1;
          end else begin
            res_status_q <= olte_pkg::ST_NOTFOUND;
            state_q      <= S_RESP;
          end
        end
        S_RESP: begin
          pend_q <= 1'b0;
          if (slot_free) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            found_q     <= olte_pkg::FoundW'(res_found_q);
            count_q     <= olte_pkg::CountW'(len_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          pend_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Length never exceeds the capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("list length above capacity");

  // The find and delete walk pointers never go beyond the list length
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND || state_q == S_DEL) |-> ptr_q <= len_q)
    else $error("walk pointer beyond list length");

  // A successful append grows the list by exactly one
  a_append_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind == olte_pkg::KIND_APPEND && !full)
      |=> len_q == $past(len_q) + 1'b1)
    else $error("append did not grow the list by one");

  // A response is only loaded when the output register is free
  a_resp_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !slot_free) |=> state_q == S_RESP)
    else $error("response left while output register busy");
`endif

endmodule
